// ===== design/content_directory_table_defines.svh =====
`ifndef CONTENT_DIRECTORY_TABLE_DEFINES_SVH
`define CONTENT_DIRECTORY_TABLE_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define CDT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("content directory table: same-cycle check failed");

// next-cycle implication, disabled while in reset
`define CDT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("content directory table: next-cycle check failed");

`endif

// ===== design/cdt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package cdt_pkg;

	localparam int FUNC_W    = 3;
	localparam int KEY_W     = 64;
	localparam int ADDR_W    = 48;
	localparam int STATUS_W  = 2;

	localparam int TABLE_DEPTH_DEF = 16;
	localparam int COUNT_WIDTH_DEF = 16;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_REGISTER   = 3'd0,
		FUNC_DEREGISTER = 3'd1,
		FUNC_SEARCH     = 3'd2,
		FUNC_LIST       = 3'd3,
		FUNC_QUIT       = 3'd4
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_FAIL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic [KEY_W-1:0]  peer;
		logic [KEY_W-1:0]  content;
		logic [ADDR_W-1:0] address;
	} entry_t;

endpackage

`default_nettype wire

// ===== design/cdt_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface cdt_req_if
	import cdt_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [FUNC_W-1:0] func;
	logic [KEY_W-1:0]  peer_key;
	logic [KEY_W-1:0]  content_key;
	logic [ADDR_W-1:0] peer_address;

	modport source (output valid, func, peer_key, content_key, peer_address, input ready);
	modport sink (input valid, func, peer_key, content_key, peer_address, output ready);
endinterface

interface cdt_rsp_if
	import cdt_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [ADDR_W-1:0]   found_address;
	logic [KEY_W-1:0]    listed_content;
	logic                last;

	modport source (output valid, status, found_address, listed_content, last, input ready);
	modport sink (input valid, status, found_address, listed_content, last, output ready);
endinterface

`default_nettype wire

// ===== design/content_directory_table.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Directory of (peer, content, address) entries, TABLE_DEPTH deep, one request per
// transaction on req. Every request walks the whole table through a single read port of
// the entry memory, one entry per cycle with one comparator set unless a list entry waits
// on a busy result register; an unknown func skips the walk. The result of a request is
// offered after the walk and req turns ready again in that same cycle, so the next
// request waits until then, and longer while rsp is stalled. List streams one result per
// valid entry during the walk; every other request gives one result, loaded in the
// commit cycle after the walk. req is ready only while no request is in progress; the
// result register lets the next request in while the last result still waits on rsp.
// No clearing pass: use counts are written whenever an entry is created, so only the
// valid bits are reset.
module content_directory_table
	import cdt_pkg::*;
#(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  wire        clk,
	input  wire        arst_n,
	cdt_req_if.sink    req,
	cdt_rsp_if.source  rsp
);

	localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	// entry storage
	entry_t                 key_mem  [TABLE_DEPTH];
	logic [COUNT_WIDTH-1:0] uses_mem [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] valid_q;

	state_t state_q, state_d;

	logic [FUNC_W-1:0]  func_q;
	logic [KEY_W-1:0]   peer_q;
	logic [KEY_W-1:0]   content_q;
	logic [ADDR_W-1:0]  addr_q;
	logic [CW-1:0]      cnt_q;

	logic               s1_vld_q;
	logic [IW-1:0]      idx_s1;
	entry_t             key_s1;
	logic [COUNT_WIDTH-1:0] uses_s1;

	logic               found_q;
	logic               dup_q;
	logic               any_listed_q;
	logic [IW-1:0]      sel_idx_q;
	logic [COUNT_WIDTH-1:0] best_uses_q;
	logic [ADDR_W-1:0]  best_addr_q;

	logic                rsp_valid_q;
	logic [STATUS_W-1:0] rsp_status_q;
	logic [ADDR_W-1:0]   rsp_addr_q;
	logic [KEY_W-1:0]    rsp_content_q;
	logic                rsp_last_q;

	// control
	logic               accept;
	logic               out_free;
	logic               advance;
	logic               issue;
	logic               process;
	logic [IW-1:0]      rd_idx;
	logic               s1_v;
	logic               s1_peer_eq;
	logic               s1_content_eq;
	logic [TABLE_DEPTH-1:0] upto_mask;
	logic               list_last;
	logic               take;
	logic               dup_set;
	logic               emit;
	logic [STATUS_W-1:0] emit_status;
	logic [ADDR_W-1:0]  emit_addr;
	logic [KEY_W-1:0]   emit_content;
	logic               emit_last;
	logic               key_we;
	logic               uses_we;
	logic [IW-1:0]      wr_idx;
	logic [COUNT_WIDTH-1:0] uses_wdata;
	logic               valid_we;
	logic               valid_wval;
	logic [IW-1:0]      valid_idx;

	assign accept   = req.valid && req.ready;
	assign out_free = !rsp_valid_q || rsp.ready;

	assign s1_v          = valid_q[idx_s1];
	assign s1_peer_eq    = key_s1.peer == peer_q;
	assign s1_content_eq = key_s1.content == content_q;

	// bits 0..idx_s1 set; the entry is last in a list if nothing valid lies above it
	assign upto_mask = {TABLE_DEPTH{1'b1}} >> (IW'(TABLE_DEPTH - 1) - idx_s1);
	assign list_last = (valid_q & ~upto_mask) == '0;

	// a list entry waiting on a busy result register holds the walk
	assign advance = !(state_q == S_SCAN && s1_vld_q && func_q == FUNC_LIST && s1_v
		&& !out_free);
	assign issue   = state_q == S_SCAN && advance && cnt_q < CW'(TABLE_DEPTH);
	assign process = state_q == S_SCAN && advance && s1_vld_q;
	assign rd_idx  = advance ? cnt_q[IW-1:0] : idx_s1;

	always_comb begin
		state_d      = state_q;
		req.ready    = state_q == S_IDLE;
		take         = 1'b0;
		dup_set      = 1'b0;
		emit         = 1'b0;
		emit_status  = ST_OK;
		emit_addr    = '0;
		emit_content = '0;
		emit_last    = 1'b1;
		key_we       = 1'b0;
		uses_we      = 1'b0;
		wr_idx       = sel_idx_q;
		uses_wdata   = '0;
		valid_we     = 1'b0;
		valid_wval   = 1'b0;
		valid_idx    = sel_idx_q;

		case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					if (req.func inside {FUNC_REGISTER, FUNC_DEREGISTER, FUNC_SEARCH,
						FUNC_LIST, FUNC_QUIT}) begin
						state_d = S_SCAN;
					end else begin
						state_d = S_FINISH;
					end
				end
			end
			S_SCAN: begin
				if (process) begin
					case (func_q)
						FUNC_REGISTER: begin
							dup_set = s1_v && s1_peer_eq && s1_content_eq;
							take    = !s1_v && !found_q;
						end
						FUNC_DEREGISTER: begin
							take = s1_v && s1_peer_eq && s1_content_eq && !found_q;
						end
						FUNC_SEARCH: begin
							take = s1_v && s1_content_eq
								&& (!found_q || uses_s1 < best_uses_q);
						end
						FUNC_LIST: begin
							emit         = s1_v;
							emit_content = key_s1.content;
							emit_last    = list_last;
						end
						FUNC_QUIT: begin
							valid_we  = s1_v && s1_peer_eq;
							valid_idx = idx_s1;
						end
						default: begin
						end
					endcase
				end
				if (cnt_q == CW'(TABLE_DEPTH) && !s1_vld_q) begin
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				if (func_q == FUNC_LIST && any_listed_q) begin
					state_d = S_IDLE;
				end else if (out_free) begin
					emit    = 1'b1;
					state_d = S_IDLE;
					case (func_q)
						FUNC_REGISTER: begin
							if (dup_q || !found_q) begin
								emit_status = ST_FAIL;
							end else begin
								key_we     = 1'b1;
								uses_we    = 1'b1;
								valid_we   = 1'b1;
								valid_wval = 1'b1;
							end
						end
						FUNC_DEREGISTER: begin
							if (found_q) begin
								valid_we = 1'b1;
							end else begin
								emit_status = ST_FAIL;
							end
						end
						FUNC_SEARCH: begin
							if (found_q) begin
								uses_we    = 1'b1;
								uses_wdata = (best_uses_q == '1) ? best_uses_q
									: best_uses_q + 1'b1;
								emit_addr  = best_addr_q;
							end else begin
								emit_status = ST_FAIL;
							end
						end
						FUNC_LIST: begin
							emit_status = ST_EMPTY;
						end
						FUNC_QUIT: begin
						end
						default: begin
							emit_status = ST_FAIL;
						end
					endcase
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// entry memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (key_we) begin
			key_mem[wr_idx] <= '{peer: peer_q, content: content_q, address: addr_q};
		end
		if (uses_we) begin
			uses_mem[wr_idx] <= uses_wdata;
		end
		key_s1  <= key_mem[rd_idx];
		uses_s1 <= uses_mem[rd_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (valid_we) begin
			valid_q[valid_idx] <= valid_wval;
		end
	end

	// request capture and walk control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q        <= '0;
			s1_vld_q     <= 1'b0;
			found_q      <= 1'b0;
			dup_q        <= 1'b0;
			any_listed_q <= 1'b0;
		end else begin
			if (accept) begin
				cnt_q        <= '0;
				found_q      <= 1'b0;
				dup_q        <= 1'b0;
				any_listed_q <= 1'b0;
			end else begin
				if (issue) begin
					cnt_q <= cnt_q + 1'b1;
				end
				if (take) begin
					found_q <= 1'b1;
				end
				if (dup_set) begin
					dup_q <= 1'b1;
				end
				if (emit && state_q == S_SCAN) begin
					any_listed_q <= 1'b1;
				end
			end
			if (state_q != S_SCAN) begin
				s1_vld_q <= 1'b0;
			end else if (advance) begin
				s1_vld_q <= issue;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q    <= req.func;
			peer_q    <= req.peer_key;
			content_q <= req.content_key;
			addr_q    <= req.peer_address;
		end
		if (issue) begin
			idx_s1 <= cnt_q[IW-1:0];
		end
		if (take) begin
			sel_idx_q   <= idx_s1;
			best_uses_q <= uses_s1;
			best_addr_q <= key_s1.address;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (emit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			rsp_status_q  <= emit_status;
			rsp_addr_q    <= emit_addr;
			rsp_content_q <= emit_content;
			rsp_last_q    <= emit_last;
		end
	end

	assign rsp.valid          = rsp_valid_q;
	assign rsp.status         = rsp_status_q;
	assign rsp.found_address  = rsp_addr_q;
	assign rsp.listed_content = rsp_content_q;
	assign rsp.last           = rsp_last_q;

endmodule

`default_nettype wire

// ===== design/cdt_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "content_directory_table_defines.svh"

module cdt_checker
	import cdt_pkg::*;
(
	input  wire        clk,
	input  wire        arst_n,
	cdt_req_if.sink    req,
	cdt_rsp_if.source  rsp
);

	// a waiting result stays offered
	`CDT_ASSERT_NXT(a_rsp_hold, clk, arst_n, rsp.valid && !rsp.ready, rsp.valid)

	// one request at a time: busy right after a transaction on req
	`CDT_ASSERT_NXT(a_req_busy, clk, arst_n, req.valid && req.ready, !req.ready)

	// failures and empty lists are always single results
	`CDT_ASSERT_IMP(a_fail_last, clk, arst_n, rsp.valid && rsp.status != ST_OK, rsp.last)

	`CDT_ASSERT_IMP(a_empty_clean, clk, arst_n, rsp.valid && rsp.status == ST_EMPTY,
		rsp.found_address == '0 && rsp.listed_content == '0)

	// an address only comes back on a successful search
	`CDT_ASSERT_IMP(a_addr_ok, clk, arst_n, rsp.valid && rsp.found_address != '0,
		rsp.status == ST_OK && rsp.listed_content == '0)

endmodule

bind content_directory_table cdt_checker u_cdt_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.req    (req),
	.rsp    (rsp)
);

`default_nettype wire
